// ===== sv/fpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_pkg
// Shared types, constants and helper functions of the file path validator.
// ----------------------------------------------------------------------------
package fpv_pkg;

  localparam int BYTE_W       = 8;
  localparam int TOTAL_W      = 12;
  localparam int COMP_W       = 9;
  localparam int MAXC_W       = 8;
  localparam int PREFIX_BYTES = 11;

  localparam logic [TOTAL_W-1:0] MAX_PATH_RESET = 12'd1024;
  localparam logic [MAXC_W-1:0]  MAX_COMP_RESET = 8'd255;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT      = '1;
  localparam logic [COMP_W-1:0]  COMP_SAT       = '1;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LENGTH,
    ERR_CONTROL,
    ERR_EMPTY_COMP,
    ERR_LONG_COMP,
    ERR_DOT_COMP,
    ERR_RESERVED
  } err_t;

  typedef enum logic {
    CFG_MAX_PATH,
    CFG_MAX_COMP
  } cfg_idx_t;

  // reserved component prefix, positions past its end read as zero
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = 8'h2e;
      4'd1:    b = 8'h73;
      4'd2:    b = 8'h61;
      4'd3:    b = 8'h6e;
      4'd4:    b = 8'h64;
      4'd5:    b = 8'h73;
      4'd6:    b = 8'h74;
      4'd7:    b = 8'h6f;
      4'd8:    b = 8'h72;
      4'd9:    b = 8'h6d;
      4'd10:   b = 8'h2d;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic err_t check_comp(input logic [COMP_W-1:0] cnt,
                                      input logic              dots,
                                      input logic              pfx,
                                      input logic [MAXC_W-1:0] maxc);
    err_t e;
    if (cnt == '0) begin
      e = ERR_EMPTY_COMP;
    end else if (cnt > {1'b0, maxc}) begin
      e = ERR_LONG_COMP;
    end else if (dots && cnt <= COMP_W'(2)) begin
      e = ERR_DOT_COMP;
    end else if (pfx && cnt >= COMP_W'(PREFIX_BYTES)) begin
      e = ERR_RESERVED;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

endpackage

// ===== sv/fpv_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_tracker
// Per-path state (lengths, dot and prefix flags, first error) and the
// result code for the byte presented on this cycle.
// ----------------------------------------------------------------------------
module fpv_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [fpv_pkg::BYTE_W-1:0]    path_byte,
  input  logic                          last_byte,
  input  logic                          empty_path,
  input  logic [fpv_pkg::TOTAL_W-1:0]   max_path_length,
  input  logic [fpv_pkg::MAXC_W-1:0]    max_component_length,
  output fpv_pkg::err_t                 code
);
  import fpv_pkg::*;

  logic [TOTAL_W-1:0] total_count, total_count_next;
  logic               total_over, total_over_next;
  logic [COMP_W-1:0]  comp_count, comp_count_next;
  logic               all_dots, all_dots_next;
  logic               pfx_match, pfx_match_next;
  err_t               first_error, err_next;
  err_t               slash_err;
  err_t               last_err;
  logic               is_slash;

  always_comb begin
    total_over_next  = total_over;
    total_count_next = total_count;
    if (total_count == TOTAL_SAT) begin
      total_over_next = 1'b1;
    end else begin
      total_count_next = total_count + TOTAL_W'(1);
    end

    err_next = first_error;
    if ((path_byte < CHAR_SPACE || path_byte == CHAR_DEL) && err_next == ERR_NONE) begin
      err_next = ERR_CONTROL;
    end

    is_slash        = (path_byte == CHAR_SLASH);
    slash_err       = check_comp(comp_count, all_dots, pfx_match, max_component_length);
    comp_count_next = comp_count;
    all_dots_next   = all_dots;
    pfx_match_next  = pfx_match;
    if (is_slash) begin
      if (err_next == ERR_NONE) begin
        err_next = slash_err;
      end
      comp_count_next = '0;
      all_dots_next   = 1'b1;
      pfx_match_next  = 1'b1;
    end else begin
      if (comp_count < COMP_W'(PREFIX_BYTES) && path_byte != prefix_byte(comp_count[3:0])) begin
        pfx_match_next = 1'b0;
      end
      if (path_byte != CHAR_DOT) begin
        all_dots_next = 1'b0;
      end
      if (comp_count != COMP_SAT) begin
        comp_count_next = comp_count + COMP_W'(1);
      end
    end

    // final component is checked after the last byte itself
    last_err = check_comp(comp_count_next, all_dots_next, pfx_match_next,
                          max_component_length);
    if (empty_path || total_over_next || total_count_next > max_path_length) begin
      code = ERR_LENGTH;
    end else if (err_next != ERR_NONE) begin
      code = err_next;
    end else begin
      code = last_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      total_over  <= 1'b0;
      comp_count  <= '0;
      all_dots    <= 1'b1;
      pfx_match   <= 1'b1;
      first_error <= ERR_NONE;
    end else if (go) begin
      if (empty_path || last_byte) begin
        total_count <= '0;
        total_over  <= 1'b0;
        comp_count  <= '0;
        all_dots    <= 1'b1;
        pfx_match   <= 1'b1;
        first_error <= ERR_NONE;
      end else begin
        total_count <= total_count_next;
        total_over  <= total_over_next;
        comp_count  <= comp_count_next;
        all_dots    <= all_dots_next;
        pfx_match   <= pfx_match_next;
        first_error <= err_next;
      end
    end
  end

endmodule

// ===== sv/file_path_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_path_validator
// Streaming relative path checker with a result per path.
// ----------------------------------------------------------------------------
// The path enters one byte per transaction with last_byte on the final byte;
// an empty path is a single transaction with empty_path set. The block takes
// one byte every cycle unless path_stall is high: each byte is registered,
// checked against the running path state and, on the last byte or an empty
// path, the result lands in the output register. The input stalls only
// while a result waits there with result_stall high and the registered byte
// would produce another one. error_code is 0 for a valid path, else the
// length/empty code or the first error in byte order. Limits must be written
// through the cfg port (index 0: max path length, index 1: max component
// length) by the user only while idle; the block does not enforce this.
module file_path_validator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          path_valid,
  output logic                          path_stall,
  input  logic [fpv_pkg::BYTE_W-1:0]    path_byte,
  input  logic                          last_byte,
  input  logic                          empty_path,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          path_ok,
  output logic [2:0]                    error_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [fpv_pkg::TOTAL_W-1:0]   cfg_data
);
  import fpv_pkg::*;

  logic [TOTAL_W-1:0] max_path_length;
  logic [MAXC_W-1:0]  max_component_length;

  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_last;
  logic               s1_empty;
  logic               s1_ends;
  logic               s1_go;
  logic               out_free;
  err_t               code;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign s1_ends    = s1_last || s1_empty;
  assign s1_go      = s1_valid && (!s1_ends || out_free);
  assign path_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_path_length      <= MAX_PATH_RESET;
      max_component_length <= MAX_COMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_PATH: max_path_length      <= cfg_data;
        CFG_MAX_COMP: max_component_length <= cfg_data[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!path_stall) begin
      s1_valid <= path_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (path_valid && !path_stall) begin
      s1_byte  <= path_byte;
      s1_last  <= last_byte;
      s1_empty <= empty_path;
    end
  end

  fpv_tracker u_tracker (
    .clk                  (clk),
    .rst                  (rst),
    .go                   (s1_go),
    .path_byte            (s1_byte),
    .last_byte            (s1_last),
    .empty_path           (s1_empty),
    .max_path_length      (max_path_length),
    .max_component_length (max_component_length),
    .code                 (code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_ends) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ends) begin
      path_ok    <= (code == ERR_NONE);
      error_code <= code;
    end
  end

  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (path_ok == (error_code == ERR_NONE)))
    else $error("path_ok disagrees with error_code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (error_code != 3'd7))
    else $error("error_code out of range");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("stalled byte lost from input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(error_code)))
    else $error("pending result overwritten");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming file path validator.
// ----------------------------------------------------------------------------
// Paths are queued byte by byte and fed by a clocked driver with random gaps.
// The result side applies random stall. Every accepted byte updates a local
// model of the path state, and each finished path yields an expected verdict.
// The monitor compares each result with the oldest expected verdict. The run
// opens with directed paths: dot components, the reserved prefix, control
// bytes, empty components and length limits at their edges. Random
// paths, many with faulty components, and raw noise follow under several
// limit settings, including the extremes.
module testbench;
  import fpv_pkg::*;

  typedef logic [BYTE_W-1:0] path_bytes_t[$];

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              fin;
    logic              empty;
  } path_beat_t;

  typedef struct packed {
    logic ok;
    err_t code;
  } verdict_t;

  localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
  localparam logic [BYTE_W-1:0] RESERVED_TAG [PREFIX_BYTES] = '{
    8'h2e, 8'h73, 8'h61, 8'h6e, 8'h64, 8'h73, 8'h74, 8'h6f, 8'h72, 8'h6d, 8'h2d
  };

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               path_valid   = 1'b0;
  logic               path_stall;
  logic [BYTE_W-1:0]  path_byte    = '0;
  logic               last_byte    = 1'b0;
  logic               empty_path   = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               path_ok;
  logic [2:0]         error_code;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index    = CFG_MAX_PATH;
  logic [TOTAL_W-1:0] cfg_data     = '0;

  file_path_validator u_top (
    .clk          (clk),
    .rst          (rst),
    .path_valid   (path_valid),
    .path_stall   (path_stall),
    .path_byte    (path_byte),
    .last_byte    (last_byte),
    .empty_path   (empty_path),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .path_ok      (path_ok),
    .error_code   (error_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // local copy of limits and running path state
  logic [TOTAL_W-1:0] lim_path    = MAX_PATH_RESET;
  logic [MAXC_W-1:0]  lim_comp    = MAX_COMP_RESET;
  logic [TOTAL_W-1:0] run_total   = '0;
  logic               run_over    = 1'b0;
  logic [COMP_W-1:0]  seg_len     = '0;
  logic               seg_dots    = 1'b1;
  logic               seg_tag     = 1'b1;
  err_t               first_fault = ERR_NONE;

  verdict_t   verdict_q[$];
  path_beat_t beat_q[$];
  path_beat_t cur_beat;

  int n_loaded   = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int n_mismatch = 0;
  int n_settings = 1;
  int code_hits[7];
  int send_wait  = 0;
  int send_calm  = 0;
  int recv_wait  = 0;
  int recv_calm  = 0;

  function automatic void clear_seg();
    seg_len  = '0;
    seg_dots = 1'b1;
    seg_tag  = 1'b1;
  endfunction

  function automatic void clear_run();
    run_total   = '0;
    run_over    = 1'b0;
    first_fault = ERR_NONE;
    clear_seg();
  endfunction

  function automatic err_t seg_fault();
    if (seg_len == '0) return ERR_EMPTY_COMP;
    if (seg_len > COMP_W'(lim_comp)) return ERR_LONG_COMP;
    if (seg_dots && seg_len <= COMP_W'(2)) return ERR_DOT_COMP;
    if (seg_tag && seg_len >= COMP_W'(PREFIX_BYTES)) return ERR_RESERVED;
    return ERR_NONE;
  endfunction

  function automatic void note_fault(err_t e);
    if (first_fault == ERR_NONE) first_fault = e;
  endfunction

  // advance the path state by one accepted byte, queue a verdict at path end
  function automatic void track_beat(path_beat_t bt);
    verdict_t v;
    err_t     code;
    if (bt.empty) begin
      v.ok   = 1'b0;
      v.code = ERR_LENGTH;
      verdict_q.push_back(v);
      clear_run();
      return;
    end
    if (run_total == TOTAL_SAT) run_over = 1'b1;
    else run_total++;
    if (bt.ch < CHAR_SPACE || bt.ch == CHAR_DEL) note_fault(ERR_CONTROL);
    if (bt.ch == CHAR_SLASH) begin
      note_fault(seg_fault());
      clear_seg();
    end else begin
      if (seg_len < COMP_W'(PREFIX_BYTES) && bt.ch != RESERVED_TAG[int'(seg_len)])
        seg_tag = 1'b0;
      if (bt.ch != CHAR_DOT) seg_dots = 1'b0;
      if (seg_len != COMP_SAT) seg_len++;
    end
    if (!bt.fin) return;
    note_fault(seg_fault());
    code   = (run_over || run_total > lim_path) ? ERR_LENGTH : first_fault;
    v.ok   = (code == ERR_NONE);
    v.code = code;
    verdict_q.push_back(v);
    clear_run();
  endfunction

  function automatic void check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("unexpected result: path_ok=%0b error_code=%0d", path_ok, error_code);
      return;
    end
    want = verdict_q.pop_front();
    n_checked++;
    code_hits[int'(want.code)]++;
    if (path_ok !== want.ok || error_code !== want.code) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on path %0d: expected ok=%0b code=%0d, got ok=%0b code=%0d",
                 n_checked, want.ok, want.code, path_ok, error_code);
    end
  endfunction

  // mostly busy, sometimes long waits, now and then a calm stretch
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 17);
    return 0;
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      path_valid <= 1'b0;
    end else begin
      if (path_valid && !path_stall) begin
        track_beat(cur_beat);
        n_taken++;
      end
      if (!path_valid || !path_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          path_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          cur_beat   = beat_q.pop_front();
          path_byte  <= cur_beat.ch;
          last_byte  <= cur_beat.fin;
          empty_path <= cur_beat.empty;
          path_valid <= 1'b1;
          send_wait  = draw_wait(send_calm);
        end else begin
          path_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_verdict();
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        result_stall <= 1'b1;
        if (result_valid || $urandom_range(0, 1) == 0) recv_wait--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic void load_raw(logic [BYTE_W-1:0] ch, logic fin, logic empty);
    path_beat_t bt;
    bt.ch    = ch;
    bt.fin   = fin;
    bt.empty = empty;
    beat_q.push_back(bt);
    n_loaded++;
  endfunction

  function automatic void load_path(path_bytes_t p);
    if (p.size() == 0) begin
      load_raw(BYTE_W'($urandom), 1'b1, 1'b1);
      return;
    end
    foreach (p[i]) load_raw(p[i], i == p.size() - 1, 1'b0);
  endfunction

  function automatic path_bytes_t from_text(string s);
    path_bytes_t p;
    for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
    return p;
  endfunction

  function automatic path_bytes_t fill_bytes(int n, logic [BYTE_W-1:0] ch);
    path_bytes_t p;
    for (int i = 0; i < n; i++) p.push_back(ch);
    return p;
  endfunction

  function automatic path_bytes_t tag_head(int n);
    path_bytes_t p;
    for (int i = 0; i < n; i++) p.push_back(RESERVED_TAG[i]);
    return p;
  endfunction

  // components of seg bytes joined by slashes, never ending in a slash
  function automatic path_bytes_t long_path(int n, int seg);
    path_bytes_t p;
    for (int i = 0; i < n; i++)
      p.push_back((i % (seg + 1) == seg && i != n - 1) ? CHAR_SLASH : CHAR_A);
    return p;
  endfunction

  function automatic logic [BYTE_W-1:0] plain_char();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(32'h20, 32'h7e));
    while (c == CHAR_SLASH || c == CHAR_DOT);
    return c;
  endfunction

  function automatic path_bytes_t random_segment();
    path_bytes_t s;
    int          n;
    int          kind;
    kind = $urandom_range(0, 15);
    case (kind)
      6:  s = from_text(".");
      7:  s = from_text("..");
      8:  s = fill_bytes($urandom_range(3, 4), CHAR_DOT);
      9: begin
        s = tag_head(PREFIX_BYTES);
        n = $urandom_range(0, 4);
        repeat (n) s.push_back(plain_char());
      end
      10: begin
        s = tag_head($urandom_range(1, PREFIX_BYTES - 1));
        if ($urandom_range(0, 1) == 0) s.push_back(plain_char());
      end
      11: ;
      12: begin
        if (lim_comp <= 40 || $urandom_range(0, 5) == 0)
          n = int'(lim_comp) + $urandom_range(0, 2) - 1;
        else
          n = $urandom_range(1, 12);
        if (n < 1) n = 1;
        repeat (n) s.push_back(plain_char());
      end
      13: begin
        n = $urandom_range(1, 10);
        repeat (n) s.push_back(plain_char());
        s[$urandom_range(0, n - 1)] = ($urandom_range(0, 4) == 0) ? CHAR_DEL :
                                      BYTE_W'($urandom_range(0, 31));
      end
      14: begin
        n = $urandom_range(1, 6);
        repeat (n) s.push_back(BYTE_W'($urandom));
      end
      15: begin
        s = tag_head(PREFIX_BYTES);
        s[$urandom_range(0, PREFIX_BYTES - 1)] = plain_char();
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) s.push_back(plain_char());
      end
    endcase
    return s;
  endfunction

  function automatic path_bytes_t random_path();
    path_bytes_t p;
    path_bytes_t s;
    int          n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) p.push_back(CHAR_SLASH);
    for (int i = 0; i < n; i++) begin
      if (i != 0) p.push_back(CHAR_SLASH);
      s = random_segment();
      foreach (s[j]) p.push_back(s[j]);
    end
    if ($urandom_range(0, 9) == 0) p.push_back(CHAR_SLASH);
    return p;
  endfunction

  // raw bytes with arbitrary end and empty marks, including empty mid-path
  function automatic void load_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n)
      load_raw(BYTE_W'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
  endfunction

  function automatic void load_random(int budget);
    int start;
    start = n_loaded;
    while (n_loaded - start < budget) begin
      if ($urandom_range(0, 4) == 0) load_noise();
      else load_path(random_path());
    end
    // close any open path so limits never change mid-path
    load_path(from_text("end"));
  endfunction

  // wait until every byte is taken and every verdict seen, then let the pipe drain
  task automatic settle();
    while (n_taken != n_loaded || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(cfg_idx_t idx, logic [TOTAL_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_PATH) lim_path = data;
    else lim_comp = data[MAXC_W-1:0];
  endtask

  task automatic set_limits(int max_path, int max_comp);
    settle();
    write_limit(CFG_MAX_PATH, TOTAL_W'(max_path));
    write_limit(CFG_MAX_COMP, {4'($urandom), MAXC_W'(max_comp)});
    n_settings++;
  endtask

  initial begin
    path_bytes_t p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed paths at the reset limits
    load_path(from_text("a"));
    load_path(from_text("docs/readme.txt"));
    load_path(from_text("/etc"));
    load_path(from_text("tmp/"));
    load_path(from_text("a//b"));
    load_path(from_text("."));
    load_path(from_text(".."));
    load_path(from_text("..."));
    load_path(from_text("a/../b"));
    load_path(tag_head(PREFIX_BYTES));
    p = tag_head(PREFIX_BYTES);
    p.push_back(CHAR_A);
    load_path(p);
    load_path(tag_head(PREFIX_BYTES - 1));
    p = from_text("ab?c");
    p[2] = 8'h00;
    load_path(p);
    p = from_text("x?");
    p[1] = 8'h1f;
    load_path(p);
    p = from_text("del?");
    p[3] = CHAR_DEL;
    load_path(p);
    p = from_text("sp ac??");
    p[5] = 8'h80;
    p[6] = 8'hff;
    load_path(p);
    load_path(p[0:-1]);
    // empty mark in the middle of a path drops it
    load_raw(CHAR_A, 1'b0, 1'b0);
    load_raw(CHAR_A, 1'b0, 1'b0);
    load_raw(8'h5a, 1'b0, 1'b1);
    // first error in byte order wins
    p = from_text("./?");
    p[2] = 8'h01;
    load_path(p);
    p = from_text("?/.");
    p[0] = 8'h01;
    load_path(p);
    load_path(fill_bytes(255, 8'h62));
    load_path(fill_bytes(256, 8'h62));
    load_random(100);

    // largest path limit
    set_limits(4095, 255);
    load_random(120);

    set_limits(1, 1);
    load_path(from_text("a"));
    load_path(from_text("ab"));
    load_random(100);

    // zero limits: every nonempty path is too long
    set_limits(0, 0);
    load_random(80);

    set_limits(24, 3);
    load_path(long_path(24, 2));
    load_path(long_path(25, 2));
    load_path(from_text("abc/abcd"));
    load_random(150);

    set_limits(2048, PREFIX_BYTES);
    load_path(tag_head(PREFIX_BYTES));
    p = tag_head(PREFIX_BYTES);
    p.push_back(CHAR_A);
    load_path(p);
    load_random(150);

    for (int k = 0; k < 4; k++) begin
      set_limits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) :
                                               $urandom_range(16, 160),
                 ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 24));
      load_random(130);
    end

    settle();
    $display("%0d path bytes sent, %0d path verdicts checked under %0d limit settings",
             n_taken, n_checked, n_settings);
    $display("verdicts: ok %0d, length %0d, control %0d, empty comp %0d,",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3]);
    $display("          long comp %0d, dot %0d, reserved %0d",
             code_hits[4], code_hits[5], code_hits[6]);
    if (n_mismatch == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout: %0d of %0d bytes taken, %0d verdicts pending",
             n_taken, n_loaded, verdict_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
